>>> hdl/miss_status_holding_table_assert.svh
// ----------------------------------------------------------------------------
// Miss status holding table assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MISS_STATUS_HOLDING_TABLE_ASSERT_SVH
`define MISS_STATUS_HOLDING_TABLE_ASSERT_SVH

// same-cycle implication
`define MSHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/msht_pkg.sv
// ----------------------------------------------------------------------------
// msht_pkg
// Shared widths, default parameters and codes of the miss status holding table.
// ----------------------------------------------------------------------------
package msht_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int HANDLE_BITS_DEF = 8;
  localparam int SET_BITS_DEF    = 10;
  localparam int TAG_BITS_DEF    = 22;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 8;
  localparam int ADDR_W   = 32;
  localparam int SET_W    = 10;
  localparam int TAG_W    = 22;
  localparam int BLOCK_W  = 16;
  localparam int SEL_W    = 4;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_REPLAY  = 2'd2,
    OP_DEQUEUE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_BAD_ENTRY = 2'd2
  } status_t;

endpackage

>>> hdl/msht_prio.sv
// ----------------------------------------------------------------------------
// msht_prio
// Lowest-index-first priority encoder over the entry vector.
// ----------------------------------------------------------------------------
module msht_prio import msht_pkg::*; #(
  parameter int N  = ENTRIES_DEF,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  req,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    found = |req;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

>>> hdl/miss_status_holding_table.sv
// ----------------------------------------------------------------------------
// miss_status_holding_table
// Table of outstanding cache misses: allocate, lookup, replay and dequeue.
// ----------------------------------------------------------------------------
// One word is accepted every cycle unless the result is stalled: the word is
// captured in an input register, then a single pass of parallel entry
// compares and priority encoders against the current table state produces
// the result register and the table update at the same edge, so the
// following word always sees the updated table. A stalled result holds the
// input register; throughput is one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module miss_status_holding_table import msht_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int SET_BITS    = SET_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [HANDLE_W-1:0] in_req_handle,
  input  logic [ADDR_W-1:0]   in_req_addr,
  input  logic [SET_W-1:0]    in_req_set,
  input  logic [TAG_W-1:0]    in_req_tag,
  input  logic [BLOCK_W-1:0]  in_block_number,
  input  logic [SEL_W-1:0]    in_entry_select,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [INDEX_W-1:0]  out_entry_index,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [ADDR_W-1:0]   out_addr,
  output logic [SET_W-1:0]    out_set,
  output logic [TAG_W-1:0]    out_tag,
  output logic [BLOCK_W-1:0]  out_block,
  output logic                out_pop_ready,
  output logic                out_is_empty,
  output logic                out_is_full
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HX    = (HANDLE_BITS > HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int SX    = (SET_BITS > SET_W) ? SET_BITS : SET_W;
  localparam int TX    = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;

  // input register
  logic                s_valid_r;
  op_t                 s_op_r;
  logic [HANDLE_W-1:0] s_handle_r;
  logic [ADDR_W-1:0]   s_addr_r;
  logic [SET_W-1:0]    s_set_r;
  logic [TAG_W-1:0]    s_tag_r;
  logic [BLOCK_W-1:0]  s_block_r;
  logic [SEL_W-1:0]    s_sel_r;

  // table state
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [ENTRIES-1:0]     mark_r, mark_nxt;
  logic [HANDLE_BITS-1:0] handle_mem [ENTRIES];
  logic [ADDR_W-1:0]      addr_mem   [ENTRIES];
  logic [SET_BITS-1:0]    set_mem    [ENTRIES];
  logic [TAG_BITS-1:0]    tag_mem    [ENTRIES];
  logic [BLOCK_W-1:0]     block_mem  [ENTRIES];

  // result register
  logic                o_valid_r;
  status_t             o_status_r;
  logic [INDEX_W-1:0]  o_index_r;
  logic [HANDLE_W-1:0] o_handle_r;
  logic [ADDR_W-1:0]   o_addr_r;
  logic [SET_W-1:0]    o_set_r;
  logic [TAG_W-1:0]    o_tag_r;
  logic [BLOCK_W-1:0]  o_block_r;
  logic                o_pop_r;
  logic                o_empty_r;
  logic                o_full_r;

  logic advance;
  logic in_fire;

  logic [ENTRIES-1:0] hit_req;
  logic [ENTRIES-1:0] deq_req;
  logic [ENTRIES-1:0] match;
  logic               free_found, hit_found, deq_found;
  logic [IDX_W-1:0]   free_idx, hit_idx, deq_idx;
  logic [IDX_W-1:0]   sel_idx, rd_idx;
  logic               sel_ok;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SET_BITS-1:0]    rd_set;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [BLOCK_W-1:0]     rd_block;

  logic [HX-1:0] s_handle_ext;
  logic [SX-1:0] s_set_ext;
  logic [TX-1:0] s_tag_ext;

  status_t            status_nxt;
  logic [INDEX_W-1:0] index_nxt;
  logic               wr_en;
  logic               contents_en;

  assign advance  = s_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_op_r     <= op_t'(in_operation);
      s_handle_r <= in_req_handle;
      s_addr_r   <= in_req_addr;
      s_set_r    <= in_req_set;
      s_tag_r    <= in_req_tag;
      s_block_r  <= in_block_number;
      s_sel_r    <= in_entry_select;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_req[i] = valid_r[i] && (addr_mem[i] == s_addr_r);
      match[i]   = valid_r[i] && (set_mem[i] == rd_set) && (tag_mem[i] == rd_tag);
    end
  end

  assign deq_req = valid_r & mark_r;

  msht_prio #(.N(ENTRIES), .IW(IDX_W)) u_free_prio (
    .req   (~valid_r),
    .found (free_found),
    .idx   (free_idx)
  );

  msht_prio #(.N(ENTRIES), .IW(IDX_W)) u_hit_prio (
    .req   (hit_req),
    .found (hit_found),
    .idx   (hit_idx)
  );

  msht_prio #(.N(ENTRIES), .IW(IDX_W)) u_deq_prio (
    .req   (deq_req),
    .found (deq_found),
    .idx   (deq_idx)
  );

  assign sel_idx = IDX_W'(s_sel_r);
  assign sel_ok  = (32'(s_sel_r) < ENTRIES) && valid_r[sel_idx];
  assign rd_idx  = (s_op_r == OP_REPLAY) ? sel_idx : deq_idx;

  assign rd_handle = handle_mem[rd_idx];
  assign rd_addr   = addr_mem[rd_idx];
  assign rd_set    = set_mem[rd_idx];
  assign rd_tag    = tag_mem[rd_idx];
  assign rd_block  = block_mem[rd_idx];

  assign s_handle_ext = HX'(s_handle_r);
  assign s_set_ext    = SX'(s_set_r);
  assign s_tag_ext    = TX'(s_tag_r);

  always_comb begin
    valid_nxt   = valid_r;
    mark_nxt    = mark_r;
    status_nxt  = ST_MISS;
    index_nxt   = '0;
    wr_en       = 1'b0;
    contents_en = 1'b0;
    unique case (s_op_r)
      OP_ALLOC: begin
        if (free_found) begin
          valid_nxt[free_idx] = 1'b1;
          mark_nxt[free_idx]  = 1'b0;
          wr_en               = 1'b1;
          status_nxt          = ST_OK;
          index_nxt           = INDEX_W'(free_idx);
        end
      end
      OP_LOOKUP: begin
        if (hit_found) begin
          status_nxt = ST_OK;
          index_nxt  = INDEX_W'(hit_idx);
        end
      end
      OP_REPLAY: begin
        index_nxt = INDEX_W'(s_sel_r);
        if (sel_ok) begin
          mark_nxt    = mark_r | match;
          status_nxt  = ST_OK;
          contents_en = 1'b1;
        end else begin
          status_nxt = ST_BAD_ENTRY;
        end
      end
      OP_DEQUEUE: begin
        if (deq_found) begin
          valid_nxt[deq_idx] = 1'b0;
          status_nxt         = ST_OK;
          index_nxt          = INDEX_W'(deq_idx);
          contents_en        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      mark_r  <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      handle_mem[free_idx] <= s_handle_ext[HANDLE_BITS-1:0];
      addr_mem[free_idx]   <= s_addr_r;
      set_mem[free_idx]    <= s_set_ext[SET_BITS-1:0];
      tag_mem[free_idx]    <= s_tag_ext[TAG_BITS-1:0];
      block_mem[free_idx]  <= s_block_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_status_r <= status_nxt;
      o_index_r  <= index_nxt;
      o_handle_r <= contents_en ? HANDLE_W'(rd_handle) : '0;
      o_addr_r   <= contents_en ? rd_addr : '0;
      o_set_r    <= contents_en ? SET_W'(rd_set) : '0;
      o_tag_r    <= contents_en ? TAG_W'(rd_tag) : '0;
      o_block_r  <= contents_en ? rd_block : '0;
      o_pop_r    <= |(valid_nxt & mark_nxt);
      o_empty_r  <= ~|valid_nxt;
      o_full_r   <= &valid_nxt;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_status      = o_status_r;
  assign out_entry_index = o_index_r;
  assign out_handle      = o_handle_r;
  assign out_addr        = o_addr_r;
  assign out_set         = o_set_r;
  assign out_tag         = o_tag_r;
  assign out_block       = o_block_r;
  assign out_pop_ready   = o_pop_r;
  assign out_is_empty    = o_empty_r;
  assign out_is_full     = o_full_r;

endmodule

>>> hdl/msht_checker.sv
// ----------------------------------------------------------------------------
// msht_checker
// Port-level assertions on the result channel of the miss status table.
// ----------------------------------------------------------------------------
`include "miss_status_holding_table_assert.svh"

module msht_checker import msht_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [INDEX_W-1:0]  out_entry_index,
  input logic [HANDLE_W-1:0] out_handle,
  input logic [ADDR_W-1:0]   out_addr,
  input logic [SET_W-1:0]    out_set,
  input logic [TAG_W-1:0]    out_tag,
  input logic [BLOCK_W-1:0]  out_block,
  input logic                out_pop_ready,
  input logic                out_is_empty,
  input logic                out_is_full
);

  `MSHT_ASSERT_IMP(a_status_code, out_valid, (out_status == ST_OK || out_status == ST_MISS || out_status == ST_BAD_ENTRY), "illegal status code")
  `MSHT_ASSERT_IMP(a_empty_flags, out_valid && out_is_empty, !out_pop_ready && !out_is_full, "empty table with pop_ready or full")
  `MSHT_ASSERT_IMP(a_fail_zero, out_valid && out_status != ST_OK, (out_handle == '0 && out_addr == '0 && out_set == '0 && out_tag == '0 && out_block == '0), "failed word carries contents")
  `MSHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_entry_index), "stalled result changed")

endmodule

bind miss_status_holding_table msht_checker u_msht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_index (out_entry_index),
  .out_handle      (out_handle),
  .out_addr        (out_addr),
  .out_set         (out_set),
  .out_tag         (out_tag),
  .out_block       (out_block),
  .out_pop_ready   (out_pop_ready),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miss status holding table testbench
// Drives allocate, lookup, replay and dequeue words through the valid/ready
// input channel and checks every result word against a table model kept by a
// scoreboard. Directed corner words come first (empty and full table, invalid
// replay, extreme field values), then random bursts that fill and drain the
// table with shared addresses and set/tag pairs. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import msht_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_WORDS   = 283;
  localparam int BURST_WORDS   = 32;
  localparam int MODE_MIXED    = 0;
  localparam int MODE_FILL     = 1;
  localparam int MODE_DRAIN    = 2;

  typedef struct {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   addr;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    tag;
    logic [BLOCK_W-1:0]  block;
    logic [SEL_W-1:0]    sel;
  } miss_word_t;

  typedef struct {
    status_t             status;
    logic [INDEX_W-1:0]  entry;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   addr;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    tag;
    logic [BLOCK_W-1:0]  block;
    logic                pop_ready;
    logic                is_empty;
    logic                is_full;
  } miss_result_t;

  class msht_scoreboard;
    bit           entry_valid [ENTRIES_DEF];
    bit           replay_mark [ENTRIES_DEF];
    miss_word_t   stored      [ENTRIES_DEF];
    int unsigned  occupancy;
    miss_result_t result_q[$];
    int unsigned  errors;

    function void reset_table();
      foreach (entry_valid[i]) begin
        entry_valid[i] = 1'b0;
        replay_mark[i] = 1'b0;
      end
      occupancy = 0;
      errors    = 0;
      result_q.delete();
    endfunction

    function void note_word(miss_word_t w);
      miss_result_t r;
      bit done;
      int sel;
      r.status  = ST_MISS;
      r.entry   = '0;
      r.handle  = '0;
      r.addr    = '0;
      r.set_idx = '0;
      r.tag     = '0;
      r.block   = '0;
      done      = 1'b0;
      case (w.op)
        OP_ALLOC: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!done && !entry_valid[i]) begin
              entry_valid[i] = 1'b1;
              replay_mark[i] = 1'b0;
              stored[i]      = w;
              occupancy++;
              r.status = ST_OK;
              r.entry  = i[INDEX_W-1:0];
              done     = 1'b1;
            end
          end
        end
        OP_LOOKUP: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!done && entry_valid[i] && stored[i].addr == w.addr) begin
              r.status = ST_OK;
              r.entry  = i[INDEX_W-1:0];
              done     = 1'b1;
            end
          end
        end
        OP_REPLAY: begin
          sel     = int'(w.sel);
          r.entry = w.sel;
          if (sel < ENTRIES_DEF && entry_valid[sel]) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
              if (entry_valid[i] && stored[i].set_idx == stored[sel].set_idx &&
                  stored[i].tag == stored[sel].tag) begin
                replay_mark[i] = 1'b1;
              end
            end
            r.status  = ST_OK;
            r.handle  = stored[sel].handle;
            r.addr    = stored[sel].addr;
            r.set_idx = stored[sel].set_idx;
            r.tag     = stored[sel].tag;
            r.block   = stored[sel].block;
          end else begin
            r.status = ST_BAD_ENTRY;
          end
        end
        default: begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!done && entry_valid[i] && replay_mark[i]) begin
              entry_valid[i] = 1'b0;
              if (occupancy > 0) occupancy--;
              r.status  = ST_OK;
              r.entry   = i[INDEX_W-1:0];
              r.handle  = stored[i].handle;
              r.addr    = stored[i].addr;
              r.set_idx = stored[i].set_idx;
              r.tag     = stored[i].tag;
              r.block   = stored[i].block;
              done      = 1'b1;
            end
          end
        end
      endcase
      r.pop_ready = 1'b0;
      foreach (entry_valid[i]) begin
        if (entry_valid[i] && replay_mark[i]) r.pop_ready = 1'b1;
      end
      r.is_empty = (occupancy == 0);
      r.is_full  = (occupancy == ENTRIES_DEF);
      result_q.push_back(r);
    endfunction

    function string show(miss_result_t r);
      return $sformatf("st=%0d idx=%0d h=%h a=%h s=%h t=%h b=%h pr=%b e=%b f=%b",
                       r.status, r.entry, r.handle, r.addr, r.set_idx, r.tag,
                       r.block, r.pop_ready, r.is_empty, r.is_full);
    endfunction

    function void check_word(miss_result_t got);
      miss_result_t want;
      bit bad;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t: unexpected result word %s", $time, show(got));
        return;
      end
      want = result_q.pop_front();
      bad = (got.status !== want.status) || (got.entry !== want.entry) ||
            (got.handle !== want.handle) || (got.addr !== want.addr) ||
            (got.set_idx !== want.set_idx) || (got.tag !== want.tag) ||
            (got.block !== want.block) || (got.pop_ready !== want.pop_ready) ||
            (got.is_empty !== want.is_empty) || (got.is_full !== want.is_full);
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation    = '0;
  logic [HANDLE_W-1:0] in_req_handle   = '0;
  logic [ADDR_W-1:0]   in_req_addr     = '0;
  logic [SET_W-1:0]    in_req_set      = '0;
  logic [TAG_W-1:0]    in_req_tag      = '0;
  logic [BLOCK_W-1:0]  in_block_number = '0;
  logic [SEL_W-1:0]    in_entry_select = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_entry_index;
  logic [HANDLE_W-1:0] out_handle;
  logic [ADDR_W-1:0]   out_addr;
  logic [SET_W-1:0]    out_set;
  logic [TAG_W-1:0]    out_tag;
  logic [BLOCK_W-1:0]  out_block;
  logic                out_pop_ready;
  logic                out_is_empty;
  logic                out_is_full;

  msht_scoreboard sb;
  miss_result_t   seen;
  int             send_idle = 14;
  int             recv_idle = 52;
  int unsigned    cycles    = 0;
  logic [ADDR_W-1:0] addr_pool [8];
  logic [SET_W-1:0]  set_pool  [4];
  logic [TAG_W-1:0]  tag_pool  [4];

  miss_status_holding_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_req_handle   (in_req_handle),
    .in_req_addr     (in_req_addr),
    .in_req_set      (in_req_set),
    .in_req_tag      (in_req_tag),
    .in_block_number (in_block_number),
    .in_entry_select (in_entry_select),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_handle      (out_handle),
    .out_addr        (out_addr),
    .out_set         (out_set),
    .out_tag         (out_tag),
    .out_block       (out_block),
    .out_pop_ready   (out_pop_ready),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) < recv_idle) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      seen.status    = status_t'(out_status);
      seen.entry     = out_entry_index;
      seen.handle    = out_handle;
      seen.addr      = out_addr;
      seen.set_idx   = out_set;
      seen.tag       = out_tag;
      seen.block     = out_block;
      seen.pop_ready = out_pop_ready;
      seen.is_empty  = out_is_empty;
      seen.is_full   = out_is_full;
      sb.check_word(seen);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(miss_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= w.op;
    in_req_handle   <= w.handle;
    in_req_addr     <= w.addr;
    in_req_set      <= w.set_idx;
    in_req_tag      <= w.tag;
    in_block_number <= w.block;
    in_entry_select <= w.sel;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic send_op(op_t op, logic [HANDLE_W-1:0] h, logic [ADDR_W-1:0] a,
                         logic [SET_W-1:0] s, logic [TAG_W-1:0] t,
                         logic [BLOCK_W-1:0] b, logic [SEL_W-1:0] sel);
    miss_word_t w;
    w.op      = op;
    w.handle  = h;
    w.addr    = a;
    w.set_idx = s;
    w.tag     = t;
    w.block   = b;
    w.sel     = sel;
    send_word(w);
  endtask

  function automatic miss_word_t random_word(int mode);
    miss_word_t w;
    int roll, pick, alloc_lim, lookup_lim, replay_lim;
    case (mode)
      MODE_FILL:  begin alloc_lim = 55; lookup_lim = 75; replay_lim = 90; end
      MODE_DRAIN: begin alloc_lim = 10; lookup_lim = 25; replay_lim = 60; end
      default:    begin alloc_lim = 30; lookup_lim = 50; replay_lim = 75; end
    endcase
    roll = $urandom_range(99);
    w.op = (roll < alloc_lim)  ? OP_ALLOC  :
           (roll < lookup_lim) ? OP_LOOKUP :
           (roll < replay_lim) ? OP_REPLAY : OP_DEQUEUE;
    w.handle = HANDLE_W'($urandom_range(255));
    w.addr   = ($urandom_range(99) < 70) ? addr_pool[$urandom_range(7)] : ADDR_W'($urandom);
    pick     = $urandom_range(3);
    if ($urandom_range(99) < 75) begin
      w.set_idx = set_pool[pick];
      w.tag     = tag_pool[pick];
    end else begin
      w.set_idx = SET_W'($urandom_range(1023));
      w.tag     = TAG_W'($urandom_range(22'h3fffff));
    end
    w.block = BLOCK_W'($urandom_range(65535));
    w.sel   = SEL_W'($urandom_range(15));
    return w;
  endfunction

  initial begin
    int mode;
    sb = new;
    sb.reset_table();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table corners
    send_op(OP_LOOKUP, '0, 32'h0, '0, '0, '0, '0);
    send_op(OP_DEQUEUE, '0, '0, '0, '0, '0, '0);
    send_op(OP_REPLAY, '0, '0, '0, '0, '0, 4'd0);
    send_op(OP_REPLAY, '0, '0, '0, '0, '0, 4'hf);
    // extreme field values
    send_op(OP_ALLOC, '0, '0, '0, '0, '0, '0);
    send_op(OP_ALLOC, '1, '1, '1, '1, '1, '1);
    send_op(OP_LOOKUP, '0, '1, '0, '0, '0, '0);
    send_op(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
    // fill to full, half of the entries sharing set/tag with entry 1
    for (int k = 0; k < ENTRIES_DEF - 2; k++) begin
      if (k % 2 == 0)
        send_op(OP_ALLOC, HANDLE_W'(k), ADDR_W'($urandom), '1, '1, BLOCK_W'(k), '0);
      else
        send_op(OP_ALLOC, HANDLE_W'(k), ADDR_W'($urandom), SET_W'($urandom_range(1023)),
                TAG_W'($urandom_range(22'h3fffff)), BLOCK_W'(k), '0);
    end
    send_op(OP_ALLOC, 8'h5a, 32'h1234_5678, 10'h155, 22'h2aaaaa, 16'h55aa, '0);
    send_op(OP_REPLAY, '0, '0, '0, '0, '0, 4'd1);
    send_op(OP_DEQUEUE, '0, '0, '0, '0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 14 : (phase == 1) ? 52 : 0;
      recv_idle = (phase == 0) ? 52 : (phase == 1) ? 14 : 0;
      foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
      foreach (set_pool[i]) begin
        set_pool[i] = SET_W'($urandom_range(1023));
        tag_pool[i] = TAG_W'($urandom_range(22'h3fffff));
      end
      mode = MODE_MIXED;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % BURST_WORDS == 0) mode = $urandom_range(2);
        send_word(random_word(mode));
      end
    end
    in_valid <= 1'b0;

    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/msht_pkg.sv
hdl/msht_prio.sv
hdl/miss_status_holding_table.sv
hdl/msht_checker.sv
dv/testbench.sv
